FILE: sv/htca_pkg.sv
// shared types, constants and helpers for the hash table complex accumulator
`timescale 1ns / 1ps
`default_nettype none

package htca_pkg;

   // field widths fixed by the item format
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 32;
   localparam int NORM_W   = 64;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 2;

   // key mixer constants
   localparam int          HASH_SHIFT = 33;
   localparam logic [63:0] HASH_MULT  = 64'hff51afd7ed558ccd;
   localparam logic [31:0] MULT_LO    = HASH_MULT[31:0];
   localparam logic [31:0] MULT_HI    = HASH_MULT[63:32];

   // saturation limits
   localparam logic [NORM_W-1:0]       NORM_SAT = '1;
   localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh80000000;

   // command codes
   localparam logic CMD_ACCUM = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_NEW     = 2'd0,
      STAT_ADDED   = 2'd1,
      STAT_DROPPED = 2'd2,
      STAT_CLEARED = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_H0,
      ST_H1,
      ST_H2,
      ST_H3,
      ST_HASH,
      ST_PROBE,
      ST_SQ_ORE,
      ST_SQ_OIM,
      ST_SQ_NRE,
      ST_SQ_NIM,
      ST_SQ_SUM,
      ST_WR,
      ST_WIPE,
      ST_FIN
   } state_type;

   // one memory word of the slot store
   typedef struct packed {
      logic                     valid;
      logic [KEY_W-1:0]         key;
      logic signed [VAL_W-1:0]  im;
      logic signed [VAL_W-1:0]  re;
   } slot_word_type;

   // requests from the sequencer to the slot store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_start;
   } store_cmd_type;

   // lookup result and sweep status from the slot store
   typedef struct packed {
      logic                    busy;
      logic                    hit;
      logic                    empty;
      logic signed [VAL_W-1:0] old_re;
      logic signed [VAL_W-1:0] old_im;
   } store_stat_type;

   // signed Q8.24 add with saturation
   function automatic logic signed [VAL_W-1:0] sat_add(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      logic [VAL_W:0] s;
      begin
         s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
         if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
         end
         return s[VAL_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: sv/htca_store.sv
// slot store: single-port key/value memory with lookup compare and clearing sweep
`timescale 1ns / 1ps
`default_nettype none

module htca_store #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire htca_pkg::store_cmd_type          cmd,
   input  wire logic [TABLE_BITS-1:0]            addr,
   input  wire logic [htca_pkg::KEY_W-1:0]       key,
   input  wire logic signed [htca_pkg::VAL_W-1:0] wr_re,
   input  wire logic signed [htca_pkg::VAL_W-1:0] wr_im,
   output htca_pkg::store_stat_type              stat
);
   import htca_pkg::*;

   localparam int DEPTH = 1 << TABLE_BITS;

   slot_word_type           mem [DEPTH];
   slot_word_type           rd_word_ff;
   slot_word_type           port_wdata;
   logic [TABLE_BITS-1:0]   port_addr;
   logic                    port_we;
   logic                    clr_busy_ff;
   logic [TABLE_BITS-1:0]   clr_idx_ff;

   // sweep owns the port while it runs
   always_comb begin
      port_addr = clr_busy_ff ? clr_idx_ff : addr;
      port_we   = clr_busy_ff || cmd.wr_en;
      if (clr_busy_ff) begin
         port_wdata = '0;
      end else begin
         port_wdata.valid = 1'b1;
         port_wdata.key   = key;
         port_wdata.im    = wr_im;
         port_wdata.re    = wr_re;
      end
   end

   // single-port memory, registered read
   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_wdata;
      end else if (cmd.rd_en) begin
         rd_word_ff <= mem[port_addr];
      end
   end

   // clearing sweep, one slot per cycle, also after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end else if (cmd.clr_start) begin
         clr_busy_ff <= 1'b1;
      end
   end

   // lookup decode on the read word
   always_comb begin
      stat.busy   = clr_busy_ff;
      stat.hit    = rd_word_ff.valid && (rd_word_ff.key == key);
      stat.empty  = !rd_word_ff.valid;
      stat.old_re = rd_word_ff.re;
      stat.old_im = rd_word_ff.im;
   end

   a_no_start_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_start |-> !clr_busy_ff)
      else $error("clear started while sweep running");

   a_no_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!cmd.wr_en && !cmd.rd_en))
      else $error("memory access during clearing sweep");

   a_sweep_ends_wrapped: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> (clr_idx_ff == '0))
      else $error("sweep ended before covering the whole table");

endmodule

`default_nettype wire

FILE: sv/hash_table_complex_accumulator.sv
// top level: keyed complex accumulator over a linear-probing hash table
// accumulate: response after hashing, probing P slots (P = 1 to 2^TABLE_BITS) and, for a new
//   or existing entry, squaring and writing it; the next beat is taken once the response is loaded
// the shared 33x33 multiplier (3 hash partial products, up to 4 squares) and the single-port
//   slot memory (one probe per cycle) serve one step at a time
// clear: response after a sweep over all 2^TABLE_BITS slots, one slot per cycle
// reset: synchronous, active high; the same sweep runs over all slots before
//   the first beat is taken
`timescale 1ns / 1ps
`default_nettype none

module hash_table_complex_accumulator #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_cmd,
   input  wire logic [htca_pkg::KEY_W-1:0]         req_key,
   input  wire logic signed [htca_pkg::VAL_W-1:0]  req_val_re,
   input  wire logic signed [htca_pkg::VAL_W-1:0]  req_val_im,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [htca_pkg::STATUS_W-1:0]           rsp_status,
   output logic [htca_pkg::SLOT_W-1:0]             rsp_slot,
   output logic signed [htca_pkg::VAL_W-1:0]       rsp_entry_re,
   output logic signed [htca_pkg::VAL_W-1:0]       rsp_entry_im,
   output logic [htca_pkg::NORM_W-1:0]             rsp_norm_sq
);
   import htca_pkg::*;

   state_type               state_ff, state_in;
   store_cmd_type           scmd;
   store_stat_type          sstat;
   logic [TABLE_BITS-1:0]   saddr;

   logic                    req_accept;
   logic                    out_free;

   // item registers
   logic [KEY_W-1:0]        key_ff;
   logic [KEY_W-1:0]        hx_ff;
   logic signed [VAL_W-1:0] vre_ff, vim_ff;

   // hash and probe
   logic [63:0]             acc_ff;
   logic [63:0]             hash_word;
   logic [TABLE_BITS-1:0]   hash_slot;
   logic [TABLE_BITS-1:0]   pos_ff;
   logic [TABLE_BITS-1:0]   cnt_ff;
   logic                    probe_last;

   // entry update
   logic                    hit_ff;
   logic signed [VAL_W-1:0] ore_ff, oim_ff, nre_ff, nim_ff;
   logic [63:0]             mag_ff;
   logic [NORM_W-1:0]       norm_ff;
   logic [NORM_W:0]         norm_sum;
   logic                    clr_resp_ff;

   // shared multiplier
   logic signed [VAL_W:0]   mul_a, mul_b;
   logic signed [2*VAL_W+1:0] mul_p;
   logic [63:0]             prod_ff;

   // pending result
   status_type              res_status_ff;
   logic [SLOT_W-1:0]       res_slot_ff;
   logic signed [VAL_W-1:0] res_re_ff, res_im_ff;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic signed [VAL_W-1:0] rsp_re_ff, rsp_im_ff;
   logic [NORM_W-1:0]       rsp_norm_ff;
   logic                    rsp_load;

   htca_store #(
      .TABLE_BITS (TABLE_BITS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (scmd),
      .addr  (saddr),
      .key   (key_ff),
      .wr_re (nre_ff),
      .wr_im (nim_ff),
      .stat  (sstat)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hash_word  = acc_ff ^ (acc_ff >> HASH_SHIFT);
   assign hash_slot  = hash_word[TABLE_BITS-1:0];
   assign probe_last = (cnt_ff == '1);
   assign mul_p      = mul_a * mul_b;
   assign norm_sum   = {1'b0, norm_ff} + {1'b0, mag_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_cmd == CMD_CLEAR) ? ST_WIPE : ST_H0;
            end
         end
         ST_H0:     state_in = ST_H1;
         ST_H1:     state_in = ST_H2;
         ST_H2:     state_in = ST_H3;
         ST_H3:     state_in = ST_HASH;
         ST_HASH:   state_in = ST_PROBE;
         ST_PROBE: begin
            priority if (sstat.hit) begin
               state_in = ST_SQ_ORE;
            end else if (sstat.empty) begin
               state_in = ST_SQ_NRE;
            end else if (probe_last) begin
               state_in = ST_FIN;
            end
         end
         ST_SQ_ORE: state_in = ST_SQ_OIM;
         ST_SQ_OIM: state_in = ST_SQ_NRE;
         ST_SQ_NRE: state_in = ST_SQ_NIM;
         ST_SQ_NIM: state_in = ST_SQ_SUM;
         ST_SQ_SUM: state_in = ST_WR;
         ST_WR:     state_in = ST_FIN;
         ST_WIPE: begin
            if (!sstat.busy) begin
               state_in = clr_resp_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands, store port, response load
   always_comb begin
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      scmd      = '0;
      saddr     = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scmd.clr_start = req_accept && (req_cmd == CMD_CLEAR);
         end
         ST_H0: begin
            mul_a = {1'b0, hx_ff[31:0]};
            mul_b = {1'b0, MULT_LO};
         end
         ST_H1: begin
            mul_a = {1'b0, hx_ff[31:0]};
            mul_b = {1'b0, MULT_HI};
         end
         ST_H2: begin
            mul_a = {1'b0, hx_ff[63:32]};
            mul_b = {1'b0, MULT_LO};
         end
         ST_HASH: begin
            scmd.rd_en = 1'b1;
            saddr      = hash_slot;
         end
         ST_PROBE: begin
            if (!sstat.hit && !sstat.empty && !probe_last) begin
               scmd.rd_en = 1'b1;
               saddr      = pos_ff + 1'b1;
            end
         end
         ST_SQ_ORE: begin
            mul_a = {ore_ff[VAL_W-1], ore_ff};
            mul_b = {ore_ff[VAL_W-1], ore_ff};
         end
         ST_SQ_OIM: begin
            mul_a = {oim_ff[VAL_W-1], oim_ff};
            mul_b = {oim_ff[VAL_W-1], oim_ff};
         end
         ST_SQ_NRE: begin
            mul_a = {nre_ff[VAL_W-1], nre_ff};
            mul_b = {nre_ff[VAL_W-1], nre_ff};
         end
         ST_SQ_NIM: begin
            mul_a = {nim_ff[VAL_W-1], nim_ff};
            mul_b = {nim_ff[VAL_W-1], nim_ff};
         end
         ST_WR: begin
            scmd.wr_en = 1'b1;
         end
         ST_FIN: begin
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (scmd.clr_start) begin
            clr_resp_ff <= 1'b1;
         end else if (state_ff == ST_WIPE && !sstat.busy) begin
            clr_resp_ff <= 1'b0;
         end
      end
   end

   // running norm: zeroed on reset and clear; drop the old magnitude on a hit, then add the new one with saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff <= '0;
      end else if (scmd.clr_start) begin
         norm_ff <= '0;
      end else if (state_ff == ST_SQ_NIM && hit_ff && norm_ff != NORM_SAT) begin
         norm_ff <= norm_ff - mag_ff;
      end else if (state_ff == ST_WR && norm_ff != NORM_SAT) begin
         norm_ff <= norm_sum[NORM_W] ? NORM_SAT : norm_sum[NORM_W-1:0];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_p[63:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_ff <= req_key;
               hx_ff  <= req_key ^ (req_key >> HASH_SHIFT);
               vre_ff <= req_val_re;
               vim_ff <= req_val_im;
               if (req_cmd == CMD_CLEAR) begin
                  res_status_ff <= STAT_CLEARED;
                  res_slot_ff   <= '0;
                  res_re_ff     <= '0;
                  res_im_ff     <= '0;
               end
            end
         end
         ST_H1: acc_ff <= prod_ff;
         ST_H2: acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
         ST_H3: acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
         ST_HASH: begin
            pos_ff <= hash_slot;
            cnt_ff <= '0;
         end
         ST_PROBE: begin
            priority if (sstat.hit) begin
               hit_ff <= 1'b1;
               ore_ff <= sstat.old_re;
               oim_ff <= sstat.old_im;
               nre_ff <= sat_add(sstat.old_re, vre_ff);
               nim_ff <= sat_add(sstat.old_im, vim_ff);
            end else if (sstat.empty) begin
               hit_ff <= 1'b0;
               nre_ff <= vre_ff;
               nim_ff <= vim_ff;
            end else if (probe_last) begin
               res_status_ff <= STAT_DROPPED;
               res_slot_ff   <= '0;
               res_re_ff     <= '0;
               res_im_ff     <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_SQ_OIM: mag_ff <= prod_ff;
         ST_SQ_NRE: mag_ff <= mag_ff + prod_ff;
         ST_SQ_NIM: mag_ff <= prod_ff;
         ST_SQ_SUM: mag_ff <= mag_ff + prod_ff;
         ST_WR: begin
            res_status_ff <= hit_ff ? STAT_ADDED : STAT_NEW;
            res_slot_ff   <= SLOT_W'(pos_ff);
            res_re_ff     <= nre_ff;
            res_im_ff     <= nim_ff;
         end
         default: ;
      endcase
   end

   // output register, taken while the consumer does not stall
   always_comb begin
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_re_ff     <= res_re_ff;
         rsp_im_ff     <= res_im_ff;
         rsp_norm_ff   <= norm_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_entry_re = rsp_re_ff;
   assign rsp_entry_im = rsp_im_ff;
   assign rsp_norm_sq  = rsp_norm_ff;

   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_cmd == CMD_CLEAR) |=> (state_ff == ST_WIPE && sstat.busy))
      else $error("clear beat did not start the sweep");

   a_norm_sticky: assert property (@(posedge clock) disable iff (reset)
      (norm_ff == NORM_SAT && !scmd.clr_start) |=> (norm_ff == NORM_SAT))
      else $error("saturated norm left saturation without a clear");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finish state");

   a_write_sets_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |=>
         (state_ff == ST_FIN && (res_status_ff == STAT_NEW || res_status_ff == STAT_ADDED)))
      else $error("slot write without a stored or added status");

endmodule

`default_nettype wire
